@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define SNC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define SNC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/snc_pkg.sv @@
// ----------------------------------------------------------------------------
// snc_pkg
// types, codes and character helpers of the read-name coordinate parser
// ----------------------------------------------------------------------------
`default_nettype none

package snc_pkg;

  localparam int HEAD_CHARS = 10;
  localparam int TAIL_CHARS = 7;
  localparam int CNT_W      = 4;
  localparam int Q_W        = 26;  // five base-36 symbols fit in 26 bits
  localparam int Y_BITS     = 12;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  // platform modes
  localparam logic [1:0] MODE_FOUR  = 2'd0;
  localparam logic [1:0] MODE_THREE = 2'd1;
  localparam logic [1:0] MODE_B36   = 2'd2;

  // parse status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;

  // register indexes
  localparam logic REG_PLATFORM_MODE = 1'b0;
  localparam logic REG_OUTPUT_COUNT  = 1'b1;

  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef struct packed {
    logic [31:0]                    run_value;
    logic [2:0][31:0]               prior;     // newest first
    logic [CNT_W-1:0]               hex_len;
    logic                           seen_non_hex;
    logic [CNT_W-1:0]               char_cnt;
    logic [HEAD_CHARS-1:0][3:0]     head;
    logic [TAIL_CHARS-1:0][7:0]     tail;      // index 0 is the oldest
  } name_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] coord3;
    logic [31:0] coord2;
    logic [31:0] coord1;
    logic [31:0] coord0;
  } result_t;

  function automatic logic is_digit(input logic [7:0] ch);
    return ch inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  // hex value, or HEX_NONE
  function automatic logic [4:0] hex_of(input logic [7:0] ch);
    logic [4:0] v;
    v = HEX_NONE;
    if (is_digit(ch)) v = {1'b0, ch[3:0]};
    else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) v = 5'(ch[2:0]) + 5'd9;
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/snc_decode.sv @@
// ----------------------------------------------------------------------------
// snc_decode
// forms the coordinates and status of a finished name from its parse state
// ----------------------------------------------------------------------------
`default_nettype none

module snc_decode (
  input  wire logic [1:0]          mode,
  input  wire logic [2:0]          out_count,
  input  wire snc_pkg::name_state_t st,
  output snc_pkg::result_t         res
);
  import snc_pkg::*;

  // place weights of the five base-36 symbols
  localparam int W1 = 36;
  localparam int W2 = W1 * W1;
  localparam int W3 = W2 * W1;
  localparam int W4 = W3 * W1;

  logic            newer;
  logic [Q_W-1:0]  q;
  logic            q_bad;
  logic [7:0]      sym;
  logic [5:0]      sym_val [TAIL_CHARS-2];
  logic [6:0]      region;
  logic [31:0]     c [4];
  logic [1:0]      status;

  // symbol values side by side, then one weighted sum for q
  always_comb begin
    q_bad = 1'b0;
    sym   = '0;
    for (int k = 0; k < TAIL_CHARS - 2; k++) begin
      sym = st.tail[k+2];
      if (is_digit(sym)) sym_val[k] = 6'(sym[3:0]) + 6'd26;
      else if (is_alpha(sym)) sym_val[k] = 6'((sym & 8'hDF) - 8'h41);
      else begin
        sym_val[k] = '0;
        q_bad      = 1'b1;
      end
    end
    q = (Q_W'(sym_val[0]) * Q_W'(W4) + Q_W'(sym_val[1]) * Q_W'(W3)) +
        (Q_W'(sym_val[2]) * Q_W'(W2) + Q_W'(sym_val[3]) * Q_W'(W1)) +
        Q_W'(sym_val[4]);
    region = 7'(st.tail[0][3:0]) * 7'd10 + 7'(st.tail[1][3:0]);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) c[k] = '0;
    status = ST_OK;
    if (st.seen_non_hex) newer = st.hex_len < CNT_W'(HEAD_CHARS - 2);
    else                 newer = st.char_cnt < CNT_W'(HEAD_CHARS - 1);

    if (mode == MODE_B36) begin
      if (st.char_cnt < CNT_W'(TAIL_CHARS)) status = ST_SHORT;
      else if (!is_digit(st.tail[0]) || !is_digit(st.tail[1]) || q_bad) status = ST_CORRUPT;
      else begin
        c[2] = 32'(region);
        c[1] = 32'(q[Q_W-1:Y_BITS]);
        c[0] = 32'(q[Y_BITS-1:0]);
      end
    end else begin
      if (newer) begin
        c[0] = st.run_value;
        c[1] = st.prior[0];
        c[2] = st.prior[1];
        c[3] = st.prior[2];
      end else begin
        // older layout: hex groups of 1, 3, 3 and 3 characters
        c[3] = 32'(st.head[0]);
        c[2] = 32'({st.head[1], st.head[2], st.head[3]});
        c[1] = 32'({st.head[4], st.head[5], st.head[6]});
        c[0] = 32'({st.head[7], st.head[8], st.head[9]});
      end
      if (mode != MODE_FOUR) c[3] = '0;
    end

    // coordinates past the delivered count are zero
    for (int k = 0; k < 4; k++) begin
      if (out_count <= 3'(k)) c[k] = '0;
    end

    res.coord0 = c[0];
    res.coord1 = c[1];
    res.coord2 = c[2];
    res.coord3 = c[3];
    res.status = status;
  end

endmodule

`default_nettype wire

@@ rtl/spot_name_coordinate_parser_top.sv @@
// ----------------------------------------------------------------------------
// spot_name_coordinate_parser_top
// read-name coordinate parser, one name character per request
// ----------------------------------------------------------------------------
// The block takes a read name one character per request on the in_ stream,
// with in_tlast on the final character, and returns one result request per
// name on the out_ stream. It sustains one character per clock while
// in_tready is high: every character goes through an input register and
// one pass of short logic (a shift-add for the decimal run, a
// constant-weighted sum for the base-36 symbols) into the state and, on
// the last character, into the result register. in_tready drops only
// while a last character waits behind a result that out_tready has not
// yet taken. There is no memory and no start-up sweep; the block is ready
// right after reset. Registers are to be written through cfg_ only while
// no name is in flight; the block itself does not enforce this.
`default_nettype none

module spot_name_coordinate_parser_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // config write port
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [2:0]   cfg_wdata,
  // character stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // name_char[7:0]
  input  wire logic         in_tlast,   // last_char
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata   // coord0, coord1, coord2, coord3, parse_status, 6'b0
);
  import snc_pkg::*;

  // config registers
  logic [1:0] mode_r;
  logic [2:0] count_r;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // per-name parse state
  name_state_t st_r, st_nxt, st_upd;

  // result register
  logic         out_valid_r, out_valid_nxt;
  result_t      out_res_r;
  result_t      res;

  logic       s1_adv;
  logic       in_acc;
  logic [4:0] hv;

  // the input stage moves on unless a last character finds the result slot full
  assign s1_adv    = !s1_last_r || !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_FOUR;
      count_r <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PLATFORM_MODE: mode_r  <= cfg_wdata[1:0];
        REG_OUTPUT_COUNT:  count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // state after the character held in the input stage
  always_comb begin
    st_upd = st_r;
    hv     = hex_of(s1_char_r);

    for (int i = 0; i < HEAD_CHARS; i++) begin
      if (st_r.char_cnt == CNT_W'(i)) st_upd.head[i] = (hv == HEX_NONE) ? 4'd0 : hv[3:0];
    end
    if (st_r.char_cnt != CNT_MAX) st_upd.char_cnt = st_r.char_cnt + CNT_W'(1);

    st_upd.tail = {s1_char_r, st_r.tail[TAIL_CHARS-1:1]};

    if (hv != HEX_NONE) begin
      if (st_r.hex_len != CNT_MAX) st_upd.hex_len = st_r.hex_len + CNT_W'(1);
    end else begin
      st_upd.hex_len      = '0;
      st_upd.seen_non_hex = 1'b1;
    end

    // decimal run, mod 2^32; a non-digit closes the run
    if (is_digit(s1_char_r)) begin
      st_upd.run_value = (st_r.run_value << 3) + (st_r.run_value << 1) +
                         32'(s1_char_r[3:0]);
    end else begin
      st_upd.prior[2]  = st_r.prior[1];
      st_upd.prior[1]  = st_r.prior[0];
      st_upd.prior[0]  = st_r.run_value;
      st_upd.run_value = '0;
    end
  end

  snc_decode u_decode (
    .mode      (mode_r),
    .out_count (count_r),
    .st        (st_upd),
    .res       (res)
  );

  always_comb begin
    st_nxt = st_r;
    if (s1_valid_r && s1_adv) st_nxt = s1_last_r ? name_state_t'('0) : st_upd;

    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_valid_r && s1_last_r && s1_adv) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_valid_r && s1_last_r && s1_adv) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.status, out_res_r.coord3, out_res_r.coord2,
                       out_res_r.coord1, out_res_r.coord0};

endmodule

`default_nettype wire

@@ rtl/snc_checker.sv @@
// ----------------------------------------------------------------------------
// snc_checker
// port-level checks of the read-name coordinate parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module snc_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [135:0] out_tdata
);

  // a stalled result holds its value
  `SNC_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // reset empties the result slot
  `SNC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // input back-pressure only comes from a stalled result
  `SNC_ASSERT(a_stall_cause, clk, rst_n, !in_tready |-> out_tvalid && !out_tready, "input stalled without a waiting result")

  // padding is zero and status is a defined code
  `SNC_ASSERT(a_out_codes, clk, rst_n, out_tvalid |-> out_tdata[135:130] == 6'd0 && out_tdata[129:128] != 2'd3, "bad result padding or status")

endmodule

bind spot_name_coordinate_parser_top snc_checker u_snc_checker (.*);

`default_nettype wire
